// ===== hw/rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

  localparam int HUE_W     = 13;
  localparam int PCT_W     = 7;
  localparam int CHAN_W    = 16;
  localparam int ALPHA_W   = 16;
  localparam int PRODUCT_W = 2 * PCT_W;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam int QUEUE_DEPTH = 4;

  // 60 degree hue sectors, named by the colours at their ends
  typedef enum logic [2:0] {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } sector_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/hsv2rgb_front.sv =====
module hsv2rgb_front
  import hsv2rgb_pkg::*;
#(
  parameter int HUE_FRAC_BITS = 4,
  parameter int NUM_W = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [HUE_W-1:0]   hue,
  input  logic [PCT_W-1:0]   saturation,
  input  logic [PCT_W-1:0]   brightness,
  input  logic [ALPHA_W-1:0] alpha_in,
  input  q_stat_t            q_stat,
  output logic               q_push,
  output logic [ALPHA_W+3*NUM_W-1:0] q_data
);

  localparam int SW      = 60 << HUE_FRAC_BITS;
  localparam int HUE_MAX = (360 << HUE_FRAC_BITS) - 1;
  localparam int TW      = $clog2(SW + 1);

  // stage 1: clamp, sector, distance into sector, percent products
  logic                 s1_v;
  sector_t              s1_sector;
  logic [TW-1:0]        s1_t;
  logic [PRODUCT_W-1:0] s1_vs;
  logic [PRODUCT_W-1:0] s1_vms;
  logic [NUM_W-1:0]     s1_nc;
  logic [ALPHA_W-1:0]   s1_alpha;

  // stage 2: channel numerators
  logic               s2_v;
  logic [NUM_W-1:0]   s2_r;
  logic [NUM_W-1:0]   s2_g;
  logic [NUM_W-1:0]   s2_b;
  logic [ALPHA_W-1:0] s2_alpha;

  logic en1, en2;

  assign en2      = !s2_v || !q_stat.full;
  assign en1      = !s1_v || en2;
  assign in_ready = en1;
  assign q_push   = s2_v && !q_stat.full;
  assign q_data   = {s2_alpha, s2_r, s2_g, s2_b};

  logic [HUE_W-1:0] h_cl;
  logic [PCT_W-1:0] s_cl;
  logic [PCT_W-1:0] v_cl;
  sector_t          sector;
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] rem;
  logic [TW-1:0]    t;

  always_comb begin
    h_cl = (32'(hue) > 32'(HUE_MAX)) ? HUE_W'(HUE_MAX) : hue;
    s_cl = (saturation > PCT_FULL) ? PCT_FULL : saturation;
    v_cl = (brightness > PCT_FULL) ? PCT_FULL : brightness;

    if (32'(h_cl) >= 32'(5 * SW)) begin
      sector = SEC_MAGENTA_RED;
    end else if (32'(h_cl) >= 32'(4 * SW)) begin
      sector = SEC_BLUE_MAGENTA;
    end else if (32'(h_cl) >= 32'(3 * SW)) begin
      sector = SEC_CYAN_BLUE;
    end else if (32'(h_cl) >= 32'(2 * SW)) begin
      sector = SEC_GREEN_CYAN;
    end else if (32'(h_cl) >= 32'(SW)) begin
      sector = SEC_YELLOW_GREEN;
    end else begin
      sector = SEC_RED_YELLOW;
    end

    case (sector)
      SEC_YELLOW_GREEN: base = HUE_W'(SW);
      SEC_GREEN_CYAN:   base = HUE_W'(2 * SW);
      SEC_CYAN_BLUE:    base = HUE_W'(3 * SW);
      SEC_BLUE_MAGENTA: base = HUE_W'(4 * SW);
      SEC_MAGENTA_RED:  base = HUE_W'(5 * SW);
      default:          base = '0;
    endcase
    rem = h_cl - base;

    // odd sectors fall from chroma towards zero
    if (sector[0]) begin
      t = TW'(SW) - TW'(rem);
    end else begin
      t = TW'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (en1) begin
        s1_v <= in_valid;
      end
      if (en2) begin
        s2_v <= s1_v;
      end
    end
  end

  logic [NUM_W-1:0] nm, nx;

  always_comb begin
    nm = NUM_W'(s1_vms) * NUM_W'(SW);
    nx = NUM_W'(s1_vs) * NUM_W'(s1_t) + nm;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sector <= sector;
      s1_t      <= t;
      s1_vs     <= PRODUCT_W'(v_cl) * PRODUCT_W'(s_cl);
      s1_vms    <= PRODUCT_W'(v_cl) * PRODUCT_W'(PCT_FULL - s_cl);
      s1_nc     <= NUM_W'(v_cl) * NUM_W'(100 * SW);
      s1_alpha  <= alpha_in;
    end
    if (en2) begin
      s2_alpha <= s1_alpha;
      case (s1_sector)
        SEC_RED_YELLOW: begin
          s2_r <= s1_nc; s2_g <= nx;    s2_b <= nm;
        end
        SEC_YELLOW_GREEN: begin
          s2_r <= nx;    s2_g <= s1_nc; s2_b <= nm;
        end
        SEC_GREEN_CYAN: begin
          s2_r <= nm;    s2_g <= s1_nc; s2_b <= nx;
        end
        SEC_CYAN_BLUE: begin
          s2_r <= nm;    s2_g <= nx;    s2_b <= s1_nc;
        end
        SEC_BLUE_MAGENTA: begin
          s2_r <= nx;    s2_g <= nm;    s2_b <= s1_nc;
        end
        default: begin
          s2_r <= s1_nc; s2_g <= nm;    s2_b <= nx;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/hsv2rgb_queue.sv =====
module hsv2rgb_queue
  import hsv2rgb_pkg::*;
#(
  parameter int DATA_W = 100
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output q_stat_t           stat
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign stat.full  = (count == CW'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/hsv2rgb_back.sv =====
module hsv2rgb_back
  import hsv2rgb_pkg::*;
#(
  parameter int COLOR_BITS = 16,
  parameter int HUE_FRAC_BITS = 4,
  parameter int NUM_W = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  q_stat_t            q_stat,
  input  logic [ALPHA_W+3*NUM_W-1:0] q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAN_W-1:0]  red,
  output logic [CHAN_W-1:0]  green,
  output logic [CHAN_W-1:0]  blue,
  output logic [ALPHA_W-1:0] alpha_out
);

  // denominator 10000 * 60 * 2^HUE_FRAC_BITS is 2^(6+HUE_FRAC_BITS) times 9375
  localparam int        P_SHIFT = 6 + HUE_FRAC_BITS;
  localparam bit [63:0] ODD_DIV = 64'd9375;
  localparam bit [63:0] DENOM   = 64'd600000 << HUE_FRAC_BITS;
  localparam int        XW      = NUM_W + COLOR_BITS + 1;
  localparam bit [63:0] Y_MAX   = ((DENOM << COLOR_BITS) + DENOM / 64'd2) >> P_SHIFT;
  localparam int        YW      = $clog2(Y_MAX + 64'd1);
  localparam int        K       = YW + 14;
  localparam bit [63:0] RECIP   = ((64'd1 << K) + ODD_DIV - 64'd1) / ODD_DIV;
  localparam int        MW      = K - 13;
  localparam int        QW      = COLOR_BITS + 1;
  localparam logic [QW-1:0] FULL_CODE = {1'b0, {COLOR_BITS{1'b1}}};

  logic               b1_v;
  logic [YW-1:0]      b1_y [3];
  logic [ALPHA_W-1:0] b1_alpha;

  logic [YW-1:0]      y_in [3];
  logic [CHAN_W-1:0]  code [3];

  logic en;

  assign en    = !out_valid || out_ready;
  assign q_pop = !q_stat.empty && en;

  // scale to the colour width, add half the denominator, drop its power of two
  always_comb begin
    logic [XW-1:0] x;
    x = '0;
    for (int c = 0; c < 3; c++) begin
      x = (XW'(q_data[(2-c)*NUM_W +: NUM_W]) << COLOR_BITS) + XW'(DENOM / 64'd2);
      y_in[c] = YW'(x >> P_SHIFT);
    end
  end

  // divide by 9375 through its reciprocal, exact over the whole range,
  // then clip to the all-ones code
  always_comb begin
    logic [YW+MW-1:0] prod;
    logic [QW-1:0]    quo;
    prod = '0;
    quo  = '0;
    for (int c = 0; c < 3; c++) begin
      prod = (YW+MW)'(b1_y[c]) * (YW+MW)'(RECIP[MW-1:0]);
      quo  = prod[K +: QW];
      if (quo > FULL_CODE) begin
        quo = FULL_CODE;
      end
      code[c] = CHAN_W'(quo[COLOR_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_v      <= !q_stat.empty;
      out_valid <= b1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_alpha <= q_data[3*NUM_W +: ALPHA_W];
      for (int c = 0; c < 3; c++) begin
        b1_y[c] <= y_in[c];
      end
      red       <= code[0];
      green     <= code[1];
      blue      <= code[2];
      alpha_out <= b1_alpha;
    end
  end

endmodule

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// hsv to rgb colour converter
//
// input channel: in_valid / in_ready carry one colour request (hue in
// 1/2^HUE_FRAC_BITS degree, saturation and brightness in whole percent,
// alpha_in). output channel: out_valid / out_ready carry red, green, blue
// in unsigned Q0.COLOR_BITS and alpha_out copied from the request
//
// throughput: one colour per cycle, sustained, while out_ready is high
// path: the request enters the first front stage at acceptance, then
// passes through the second front stage, the queue, the back scaling
// stage and the output register, where the reciprocal multiply lands
//
// the front clamps, finds the hue sector and forms exact channel
// numerators; a four-entry queue decouples it from the back, which scales
// each numerator to the colour width with a rounded reciprocal multiply
// when the receiver stalls, the back pipeline and output register hold; the front
// keeps taking requests until the queue and its stages fill, then in_ready drops
// reset (synchronous, active high) empties the queue and clears all valids
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
#(
  parameter int COLOR_BITS = 16,
  parameter int HUE_FRAC_BITS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [HUE_W-1:0]   hue,
  input  logic [PCT_W-1:0]   saturation,
  input  logic [PCT_W-1:0]   brightness,
  input  logic [ALPHA_W-1:0] alpha_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAN_W-1:0]  red,
  output logic [CHAN_W-1:0]  green,
  output logic [CHAN_W-1:0]  blue,
  output logic [ALPHA_W-1:0] alpha_out
);

  // common denominator of all channel numerators: 10000 * sector width
  localparam int SW     = 60 << HUE_FRAC_BITS;
  localparam int NUM_W  = $clog2(10000 * SW + 1);
  localparam int DATA_W = ALPHA_W + 3 * NUM_W;
  localparam logic [CHAN_W-1:0] CODE_MAX =
    (COLOR_BITS >= CHAN_W) ? {CHAN_W{1'b1}} : CHAN_W'((1 << COLOR_BITS) - 1);

  q_stat_t           q_stat;
  logic              q_push;
  logic              q_pop;
  logic [DATA_W-1:0] q_wdata;
  logic [DATA_W-1:0] q_rdata;

  // front: clamp, sector and numerators
  hsv2rgb_front #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .NUM_W(NUM_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .hue(hue),
    .saturation(saturation),
    .brightness(brightness),
    .alpha_in(alpha_in),
    .q_stat(q_stat),
    .q_push(q_push),
    .q_data(q_wdata)
  );

  // short queue between the two halves
  hsv2rgb_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_wdata),
    .pop(q_pop),
    .pop_data(q_rdata),
    .stat(q_stat)
  );

  // back: reciprocal scaling, rounding, output register
  hsv2rgb_back #(
    .COLOR_BITS(COLOR_BITS),
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .NUM_W(NUM_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_stat(q_stat),
    .q_data(q_rdata),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red(red),
    .green(green),
    .blue(blue),
    .alpha_out(alpha_out)
  );

  // queue status is never both full and empty
  a_queue_stat : assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // reset leaves the queue empty and no output valid
  a_reset_clear : assert property (@(posedge clk)
    rst |=> (q_stat.empty && !out_valid))
    else $error("request left in flight after reset");

  // channel codes stay within the colour width
  a_code_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red <= CODE_MAX && green <= CODE_MAX && blue <= CODE_MAX))
    else $error("channel code beyond colour width");

  // a full queue always holds off pushes from the front
  a_backpressure : assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !q_push)
    else $error("push into a full queue");

endmodule
